// File: design/sorb_pkg.sv
package sorb_pkg;

    // Default sizes handed to the top level
    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 8;

    // Most entries drained for one incoming segment
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RESULTS);

    // Register word index on the APB port
    localparam logic REG_INIT_SEQ = 1'b0;

    // Descriptor fields held by one cell (handle travels separately)
    typedef struct packed {
        logic [31:0] seq_start;
        logic [31:0] seq_end;
        logic [31:0] ack_num;
        logic [15:0] length;
    } sorb_entry_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } sorb_cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DRAIN
    } sorb_state_t;

endpackage

// File: design/sorb_cell.sv
module sorb_cell #(
    parameter int HANDLE_WIDTH = sorb_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sorb_pkg::sorb_cell_ctrl_t   ctrl,
    // new descriptor, broadcast to all cells
    input  sorb_pkg::sorb_entry_t       cand_entry,
    input  logic [HANDLE_WIDTH-1:0]     new_handle,
    // lower neighbor (toward the head)
    input  logic                        prev_ins,
    input  sorb_pkg::sorb_entry_t       prev_entry,
    input  logic [HANDLE_WIDTH-1:0]     prev_handle,
    input  logic                        prev_valid,
    // upper neighbor (toward the tail)
    input  sorb_pkg::sorb_entry_t       next_entry,
    input  logic [HANDLE_WIDTH-1:0]     next_handle,
    input  logic                        next_valid,
    // this cell's contents
    output sorb_pkg::sorb_entry_t       entry,
    output logic [HANDLE_WIDTH-1:0]     handle,
    output logic                        valid,
    output logic                        ins,
    output logic                        match
);

    sorb_pkg::sorb_entry_t     entry_reg, entry_next;
    logic [HANDLE_WIDTH-1:0]   handle_reg, handle_next;
    logic                      valid_reg, valid_next;

    // Cell at or past the insert point: empty, or holding a larger start
    assign ins   = !valid_reg || (entry_reg.seq_start > cand_entry.seq_start);
    assign match = valid_reg && (entry_reg.seq_start == cand_entry.seq_start);

    // Pop shifts toward the head; insert loads here or shifts toward the tail
    always_comb
    begin
        entry_next  = entry_reg;
        handle_next = handle_reg;
        valid_next  = valid_reg;
        if (ctrl.pop)
        begin
            entry_next  = next_entry;
            handle_next = next_handle;
            valid_next  = next_valid;
        end
        else if (ctrl.insert && ins)
        begin
            if (prev_ins)
            begin
                entry_next  = prev_entry;
                handle_next = prev_handle;
                valid_next  = prev_valid;
            end
            else
            begin
                entry_next  = cand_entry;
                handle_next = new_handle;
                valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        handle_reg <= handle_next;
    end

    assign entry  = entry_reg;
    assign handle = handle_reg;
    assign valid  = valid_reg;

endmodule

// File: design/segment_reorder_buffer.sv
// Segment reorder buffer: keeps received segment descriptors sorted by start
// sequence in a chain of cells and hands out those that are in order.
// Input channel: in_valid/in_stall with seg_start, seg_end, seg_ack,
// seg_length, payload_handle. Output channel: out_valid/out_stall carrying
// one beat per drained segment, or a single status beat (delivered = 0)
// when nothing drains; last marks the final beat of each input segment.
// Drop flags are repeated on every beat of one segment.
// Flow: accept, an insert state (cells past the insert point shift), then
// one beat per cycle into the output register while out_stall is low,
// at most 16 per segment. The cell chain does one insert or pop per cycle.
// in_stall stays high from accept until the last beat is loaded into the
// output register; an output stall holds the beat and pauses draining.
// Reset empties the table and loads expected sequence and
// initial_expected_seq with 0. Writing initial_expected_seq (APB, word 0)
// also reloads the expected sequence; write only while idle.
module segment_reorder_buffer #(
    parameter int TABLE_DEPTH  = sorb_pkg::TABLE_DEPTH_DEF,
    parameter int HANDLE_WIDTH = sorb_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // APB configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // segment input
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [31:0]             seg_start,
    input  logic [31:0]             seg_end,
    input  logic [31:0]             seg_ack,
    input  logic [15:0]             seg_length,
    input  logic [HANDLE_WIDTH-1:0] payload_handle,
    // result output
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    delivered,
    output logic [31:0]             out_start,
    output logic [31:0]             out_end,
    output logic [31:0]             out_ack,
    output logic [15:0]             out_length,
    output logic [HANDLE_WIDTH-1:0] out_handle,
    output logic                    duplicate_dropped,
    output logic                    overflow_dropped,
    output logic                    last
);

    localparam int CNT_W = sorb_pkg::CNT_W;

    sorb_pkg::sorb_state_t      state_reg, state_next;
    sorb_pkg::sorb_cell_ctrl_t  ctrl;

    sorb_pkg::sorb_entry_t      seg_reg;
    logic [HANDLE_WIDTH-1:0]    seg_handle_reg;
    logic [31:0]                init_seq_reg;
    logic [31:0]                expected_reg, expected_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       dup_reg, dup_next;
    logic                       ovf_reg, ovf_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       delivered_reg, delivered_next;
    sorb_pkg::sorb_entry_t      out_entry_reg, out_entry_next;
    logic [HANDLE_WIDTH-1:0]    out_handle_reg, out_handle_next;
    logic                       out_dup_reg, out_dup_next;
    logic                       out_ovf_reg, out_ovf_next;
    logic                       last_reg, last_next;

    sorb_pkg::sorb_entry_t      cell_entry  [TABLE_DEPTH];
    logic [HANDLE_WIDTH-1:0]    cell_handle [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     cell_valid;
    logic [TABLE_DEPTH-1:0]     cell_ins;
    logic [TABLE_DEPTH-1:0]     cell_match;

    logic                       in_take;
    logic                       cfg_wr;
    logic                       slot_free;
    logic                       head_hit;
    logic                       emit;
    logic                       emit_last;
    logic                       dup_any;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == sorb_pkg::REG_INIT_SEQ);
    assign prdata = (paddr[2] == sorb_pkg::REG_INIT_SEQ) ? init_seq_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_seq_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            init_seq_reg <= pwdata;
        end
    end

    // Input capture
    assign in_stall = (state_reg != sorb_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            seg_reg.seq_start <= seg_start;
            seg_reg.seq_end   <= seg_end;
            seg_reg.ack_num   <= seg_ack;
            seg_reg.length    <= seg_length;
            seg_handle_reg    <= payload_handle;
        end
    end

    // Cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                       p_ins;
        sorb_pkg::sorb_entry_t      p_entry;
        logic [HANDLE_WIDTH-1:0]    p_handle;
        logic                       p_valid;
        sorb_pkg::sorb_entry_t      n_entry;
        logic [HANDLE_WIDTH-1:0]    n_handle;
        logic                       n_valid;

        if (i == 0)
        begin : g_head
            assign p_ins    = 1'b0;
            assign p_entry  = seg_reg;
            assign p_handle = seg_handle_reg;
            assign p_valid  = 1'b0;
        end
        else
        begin : g_body
            assign p_ins    = cell_ins[i-1];
            assign p_entry  = cell_entry[i-1];
            assign p_handle = cell_handle[i-1];
            assign p_valid  = cell_valid[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign n_entry  = seg_reg;
            assign n_handle = seg_handle_reg;
            assign n_valid  = 1'b0;
        end
        else
        begin : g_inner
            assign n_entry  = cell_entry[i+1];
            assign n_handle = cell_handle[i+1];
            assign n_valid  = cell_valid[i+1];
        end

        sorb_cell #(
            .HANDLE_WIDTH (HANDLE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cand_entry  (seg_reg),
            .new_handle  (seg_handle_reg),
            .prev_ins    (p_ins),
            .prev_entry  (p_entry),
            .prev_handle (p_handle),
            .prev_valid  (p_valid),
            .next_entry  (n_entry),
            .next_handle (n_handle),
            .next_valid  (n_valid),
            .entry       (cell_entry[i]),
            .handle      (cell_handle[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i]),
            .match       (cell_match[i])
        );
    end

    // Head-cell drain test; last unless a hit cell 1 extends under the cap
    assign dup_any   = |cell_match;
    assign slot_free = !out_valid_reg || !out_stall;
    assign head_hit  = cell_valid[0] && (cell_entry[0].seq_start == expected_reg)
                       && (cnt_reg != sorb_pkg::MAX_CNT);
    assign emit      = (state_reg == sorb_pkg::ST_DRAIN) && slot_free;
    assign emit_last = !head_hit
                       || ((cnt_reg + CNT_W'(1)) == sorb_pkg::MAX_CNT)
                       || !(cell_valid[1] && (cell_entry[1].seq_start == cell_entry[0].seq_end));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sorb_pkg::ST_IDLE;
            expected_reg  <= 32'd0;
            cnt_reg       <= '0;
            dup_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            cnt_reg       <= cnt_next;
            dup_reg       <= dup_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequencer: insert, then drain one beat per free output slot
    always_comb
    begin
        state_next      = state_reg;
        expected_next   = expected_reg;
        cnt_next        = cnt_reg;
        dup_next        = dup_reg;
        ovf_next        = ovf_reg;
        ctrl            = '0;
        out_valid_next  = out_valid_reg && out_stall;
        delivered_next  = delivered_reg;
        out_entry_next  = out_entry_reg;
        out_handle_next = out_handle_reg;
        out_dup_next    = out_dup_reg;
        out_ovf_next    = out_ovf_reg;
        last_next       = last_reg;

        if (cfg_wr)
        begin
            expected_next = pwdata;
        end

        unique case (state_reg)
            sorb_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = sorb_pkg::ST_INSERT;
                end
            end
            sorb_pkg::ST_INSERT:
            begin
                dup_next    = dup_any;
                ovf_next    = !dup_any && cell_valid[TABLE_DEPTH-1];
                ctrl.insert = !dup_any && !cell_valid[TABLE_DEPTH-1];
                cnt_next    = '0;
                state_next  = sorb_pkg::ST_DRAIN;
            end
            sorb_pkg::ST_DRAIN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_dup_next   = dup_reg;
                    out_ovf_next   = ovf_reg;
                    last_next      = emit_last;
                    if (head_hit)
                    begin
                        ctrl.pop        = 1'b1;
                        delivered_next  = 1'b1;
                        out_entry_next  = cell_entry[0];
                        out_handle_next = cell_handle[0];
                        expected_next   = cell_entry[0].seq_end;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        delivered_next  = 1'b0;
                        out_entry_next  = '0;
                        out_handle_next = '0;
                    end
                    if (emit_last)
                    begin
                        state_next = sorb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sorb_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        delivered_reg  <= delivered_next;
        out_entry_reg  <= out_entry_next;
        out_handle_reg <= out_handle_next;
        out_dup_reg    <= out_dup_next;
        out_ovf_reg    <= out_ovf_next;
        last_reg       <= last_next;
    end

    assign out_valid         = out_valid_reg;
    assign delivered         = delivered_reg;
    assign out_start         = out_entry_reg.seq_start;
    assign out_end           = out_entry_reg.seq_end;
    assign out_ack           = out_entry_reg.ack_num;
    assign out_length        = out_entry_reg.length;
    assign out_handle        = out_handle_reg;
    assign duplicate_dropped = out_dup_reg;
    assign overflow_dropped  = out_ovf_reg;
    assign last              = last_reg;

    // Table stays packed at the low cells
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("cell table not packed");

    // Pop only from a valid head that matches the expected sequence
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (cell_valid[0] && head_hit))
        else $error("pop without a matching head");

    // No insert when the segment duplicates a stored start
    a_no_dup_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |-> !dup_any)
        else $error("insert of a duplicate start");

    // The final beat of a segment returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (state_reg == sorb_pkg::ST_IDLE))
        else $error("last beat did not end the segment");

    // Drain count bounded per segment
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sorb_pkg::MAX_CNT)
        else $error("drain count over limit");

endmodule

// File: sim/segment_reorder_buffer_test.sv
`timescale 1ns / 100ps

module segment_reorder_buffer_test;

    localparam int DEPTH       = sorb_pkg::TABLE_DEPTH_DEF;
    localparam int HW          = sorb_pkg::HANDLE_WIDTH_DEF;
    localparam int RAND_ITEMS  = 380;
    localparam int SETTLE      = 8;
    localparam int STUCK_LIMIT = 3000;
    localparam logic [2:0] INIT_ADDR = {sorb_pkg::REG_INIT_SEQ, 2'b00};

    // One segment descriptor as driven on the input channel
    typedef struct packed {
        sorb_pkg::sorb_entry_t d;
        logic [HW-1:0]         h;
    } seg_item_t;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic          delivered;
        logic [31:0]   start_seq;
        logic [31:0]   end_seq;
        logic [31:0]   ack_num;
        logic [15:0]   len;
        logic [HW-1:0] handle;
        logic          dup;
        logic          ovf;
        logic          last;
    } seg_beat_t;

    // Mirror of the reorder table plus the queue of beats still owed
    class reorder_scoreboard;
        sorb_pkg::sorb_entry_t held_desc   [DEPTH];
        logic [HW-1:0]         held_handle [DEPTH];
        int            held_count;
        logic [31:0]   rcv_next;
        seg_beat_t     pending [$];
        int            errors;
        int            beats_seen;
        int            delivered_seen;
        int            dup_seen;
        int            ovf_seen;

        function new();
            held_count     = 0;
            rcv_next       = '0;
            errors         = 0;
            beats_seen     = 0;
            delivered_seen = 0;
            dup_seen       = 0;
            ovf_seen       = 0;
        endfunction

        function void load_rcv_next(logic [31:0] v);
            rcv_next = v;
        endfunction

        function logic [31:0] head_start();
            return held_desc[0].seq_start;
        endfunction

        // Insert one accepted segment, then drain whatever is now in order
        function void note_segment(seg_item_t it);
            int        i;
            int        pos;
            int        drained;
            logic      dup;
            logic      ovf;
            seg_beat_t b;
            pos = held_count;
            dup = 1'b0;
            for (i = 0; i < held_count; i++) begin
                if (held_desc[i].seq_start == it.d.seq_start) begin
                    dup = 1'b1;
                    break;
                end
                if (held_desc[i].seq_start > it.d.seq_start) begin
                    pos = i;
                    break;
                end
            end
            ovf = !dup && (held_count >= DEPTH);
            if (!dup && !ovf) begin
                for (i = held_count; i > pos; i--) begin
                    held_desc[i]   = held_desc[i-1];
                    held_handle[i] = held_handle[i-1];
                end
                held_desc[pos]   = it.d;
                held_handle[pos] = it.h;
                held_count++;
            end
            // drain while the head is the next expected sequence
            drained = 0;
            while (drained < sorb_pkg::MAX_RESULTS && held_count > 0 &&
                   held_desc[0].seq_start == rcv_next) begin
                b           = '0;
                b.delivered = 1'b1;
                b.start_seq = held_desc[0].seq_start;
                b.end_seq   = held_desc[0].seq_end;
                b.ack_num   = held_desc[0].ack_num;
                b.len       = held_desc[0].length;
                b.handle    = held_handle[0];
                b.dup       = dup;
                b.ovf       = ovf;
                rcv_next    = held_desc[0].seq_end;
                for (i = 0; i + 1 < held_count; i++) begin
                    held_desc[i]   = held_desc[i+1];
                    held_handle[i] = held_handle[i+1];
                end
                held_count--;
                drained++;
                pending.push_back(b);
            end
            // nothing drained: a single status beat
            if (drained == 0) begin
                b     = '0;
                b.dup = dup;
                b.ovf = ovf;
                pending.push_back(b);
            end
            b      = pending.pop_back();
            b.last = 1'b1;
            pending.push_back(b);
            delivered_seen += drained;
            if (dup) dup_seen++;
            if (ovf) ovf_seen++;
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(seg_beat_t got);
            seg_beat_t want;
            beats_seen++;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: start %h end %h",
                       got.start_seq, got.end_seq);
                errors++;
                return;
            end
            want = pending.pop_front();
            cmp("delivered",         32'(want.delivered), 32'(got.delivered));
            cmp("out_start",         want.start_seq,      got.start_seq);
            cmp("out_end",           want.end_seq,        got.end_seq);
            cmp("out_ack",           want.ack_num,        got.ack_num);
            cmp("out_length",        32'(want.len),       32'(got.len));
            cmp("out_handle",        32'(want.handle),    32'(got.handle));
            cmp("duplicate_dropped", 32'(want.dup),       32'(got.dup));
            cmp("overflow_dropped",  32'(want.ovf),       32'(got.ovf));
            cmp("last",              32'(want.last),      32'(got.last));
        endfunction
    endclass

    logic          clk     = 1'b0;
    logic          rst_n   = 1'b0;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [2:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [31:0]   seg_start  = '0;
    logic [31:0]   seg_end    = '0;
    logic [31:0]   seg_ack    = '0;
    logic [15:0]   seg_length = '0;
    logic [HW-1:0] payload_handle = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          delivered;
    logic [31:0]   out_start;
    logic [31:0]   out_end;
    logic [31:0]   out_ack;
    logic [15:0]   out_length;
    logic [HW-1:0] out_handle;
    logic          duplicate_dropped;
    logic          overflow_dropped;
    logic          last;

    reorder_scoreboard sb = new();

    logic quiet = 1'b0;   // no idling on either side while set
    int   items_sent = 0;
    int   cfg_writes = 0;
    int   stuck = 0;

    segment_reorder_buffer #(
        .TABLE_DEPTH  (DEPTH),
        .HANDLE_WIDTH (HW)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .seg_start         (seg_start),
        .seg_end           (seg_end),
        .seg_ack           (seg_ack),
        .seg_length        (seg_length),
        .payload_handle    (payload_handle),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .delivered         (delivered),
        .out_start         (out_start),
        .out_end           (out_end),
        .out_ack           (out_ack),
        .out_length        (out_length),
        .out_handle        (out_handle),
        .duplicate_dropped (duplicate_dropped),
        .overflow_dropped  (overflow_dropped),
        .last              (last)
    );

    always #4 clk = ~clk;

    // Result side: check accepted beats, stall at random
    always @(posedge clk)
    begin
        seg_beat_t got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.delivered = delivered;
            got.start_seq = out_start;
            got.end_seq   = out_end;
            got.ack_num   = out_ack;
            got.len       = out_length;
            got.handle    = out_handle;
            got.dup       = duplicate_dropped;
            got.ovf       = overflow_dropped;
            got.last      = last;
            sb.check_beat(got);
        end
        out_stall <= !quiet && ($urandom_range(99) < 20);
    end

    // Watchdog: cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && !out_stall))
        begin
            stuck <= 0;
        end
        else
        begin
            stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic seg_item_t mk_seg(logic [31:0] s, logic [31:0] e);
        seg_item_t it;
        it.d.seq_start = s;
        it.d.seq_end   = e;
        it.d.ack_num   = $urandom;
        it.d.length    = 16'($urandom);
        it.h           = HW'($urandom);
        return it;
    endfunction

    // Send one descriptor; in_valid is left high after the accept
    task automatic drive_segment(seg_item_t it);
        while (!quiet && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        seg_start      <= it.d.seq_start;
        seg_end        <= it.d.seq_end;
        seg_ack        <= it.d.ack_num;
        seg_length     <= it.d.length;
        payload_handle <= it.h;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_segment(it);
        items_sent++;
    endtask

    // Hold the sender off until every owed beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Program the initial expected sequence while idle, then read it back
    task automatic set_rcv_next(logic [31:0] v);
        logic [31:0] rd;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INIT_ADDR;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.load_rcv_next(v);
        cfg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== v)
        begin
            $error("initial_expected_seq readback mismatch: expected %h, got %h", v, rd);
            sb.errors++;
        end
    endtask

    // Empty the table: point the expected sequence at the head, then
    // resend the head start as a duplicate so it drains
    task automatic flush_table();
        logic [31:0] h;
        while (sb.held_count > 0)
        begin
            h = sb.head_start();
            set_rcv_next(h);
            drive_segment(mk_seg(h, $urandom));
        end
    endtask

    initial
    begin
        seg_item_t   it;
        seg_item_t   chain [$];
        logic [31:0] base;
        logic [31:0] cur;
        logic [31:0] step;
        int          n;
        int          j;
        int          k;
        int          phase;
        int          first_rand;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset value of the expected sequence, out of order,
        // duplicate, stale segment below the expected sequence
        it = mk_seg(32'd0, 32'd100);
        it.d.ack_num = '0;
        it.d.length  = '0;
        it.h         = '0;
        drive_segment(it);
        drive_segment(mk_seg(32'd300, 32'd400));
        drive_segment(mk_seg(32'd300, 32'd350));
        drive_segment(mk_seg(32'd100, 32'd300));
        drive_segment(mk_seg(32'd50, 32'd60));
        wait_drained();
        flush_table();

        // Directed: fill the table in reverse near the top of the sequence
        // space, overflow, duplicate while full, then a full 16-beat drain
        // whose last end wraps to zero
        set_rcv_next(32'd0);
        base = 32'hFFFF_FF00;
        for (k = DEPTH - 1; k >= 0; k--)
            drive_segment(mk_seg(base + 32'(16 * k), base + 32'(16 * (k + 1))));
        it.d.seq_start = '1;
        it.d.seq_end   = '1;
        it.d.ack_num   = '1;
        it.d.length    = '1;
        it.h           = '1;
        drive_segment(it);
        drive_segment(mk_seg(base + 32'd32, 32'd7));
        set_rcv_next(base);
        drive_segment(mk_seg(base, 32'd9));
        // zero-length segment at the wrapped expected sequence
        it = mk_seg(32'd0, 32'd0);
        it.d.ack_num = '0;
        it.d.length  = '0;
        it.h         = '0;
        drive_segment(it);

        // Random phases: mostly shuffled contiguous runs, some broken runs,
        // extra duplicates and stray segments
        first_rand = items_sent;
        phase = 0;
        while (items_sent - first_rand < RAND_ITEMS)
        begin
            quiet = (phase >= 6 && phase < 11);
            if (sb.held_count > 8 || (sb.held_count > 0 && $urandom_range(99) < 70))
                flush_table();
            case ($urandom_range(9))
                0: base = 32'd0;
                1: base = 32'hFFFF_FFFF;
                2: base = 32'hFFFF_FFFF - $urandom_range(3000);
                default: base = $urandom;
            endcase
            if (phase == 0)
                base = 32'hFFFF_FFFF;
            set_rcv_next(base);

            n = ($urandom_range(99) < 15) ? $urandom_range(17, 20) : $urandom_range(1, 12);
            chain.delete();
            cur = base;
            for (j = 0; j < n; j++)
            begin
                step = ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(1, 1460));
                it = mk_seg(cur, cur + step);
                if ($urandom_range(3) != 0)
                    it.d.length = step[15:0];
                chain.push_back(it);
                cur = cur + step;
            end
            // shuffle most runs
            if ($urandom_range(3) != 0)
            begin
                for (j = n - 1; j > 0; j--)
                begin
                    k = $urandom_range(j);
                    it = chain[j];
                    chain[j] = chain[k];
                    chain[k] = it;
                end
            end
            if (chain.size() > 1 && $urandom_range(99) < 20)
                chain.delete($urandom_range(chain.size() - 1));
            if ($urandom_range(99) < 20)
            begin
                it = chain[$urandom_range(chain.size() - 1)];
                it.d.ack_num = $urandom;
                chain.insert($urandom_range(chain.size()), it);
            end
            if ($urandom_range(99) < 20)
                chain.insert($urandom_range(chain.size()), mk_seg($urandom, $urandom));

            foreach (chain[j])
            begin
                if ($urandom_range(99) < 5)
                    wait_drained();
                drive_segment(chain[j]);
            end
            phase++;
        end
        quiet = 1'b0;

        // Wind down
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d segments and %0d result beats over %0d settings",
                 items_sent, sb.beats_seen, cfg_writes);
        $display("  %0d delivered in order, %0d duplicate drops, %0d overflow drops",
                 sb.delivered_seen, sb.dup_seen, sb.ovf_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
